FILE: rtl/mnpd_pkg.sv
// Shared types, constants and arithmetic helpers of the mean-nearest-pixel denoiser.
// Used by the top module, mnpd_front and mnpd_pick; no dependencies.
`default_nettype none
package mnpd_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int STORED_ROWS   = 4;
   localparam int MIN_DIM       = 5;
   localparam int MAX_HEIGHT    = 2048;
   localparam int IN_ROW_W      = 12;
   localparam int OUT_ROW_W     = 11;
   localparam int CFG_WIDTH_W   = 11;
   localparam int CFG_HEIGHT_W  = 12;
   localparam int CSR_DATA_W    = 12;
   localparam int CSR_IDX_W     = 1;
   localparam int SET_SMALL     = 9;
   localparam int SET_LARGE     = 13;
   localparam int DIST_W        = 10;
   localparam int TREE_N        = 16;
   localparam int TREE_IDX_W    = 4;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic [CFG_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [CFG_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

   // Blue in [7:0], green in [15:8], red in [23:16].
   typedef logic [23:0] pixel_type;
   typedef logic [24:0][23:0] window_type;
   typedef logic [SET_LARGE-1:0][23:0] set_type;
   typedef logic [TREE_N-1:0][DIST_W:0] tree_type;

   typedef struct packed {
      logic filt;
      logic done;
   } tag_type;

   function automatic logic [7:0] chan(pixel_type p, int c);
      return p[8*c +: 8];
   endfunction

   function automatic logic [7:0] absdiff(logic [7:0] a, logic [7:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // Truncated s/9 for s <= 9*255 by reciprocal multiply.
   function automatic logic [7:0] mean_small(logic [11:0] s);
      logic [23:0] prod;
      prod = 24'(s) * 24'd3641;
      return prod[22:15];
   endfunction

   // Truncated s/13 for s <= 13*255 by reciprocal multiply.
   function automatic logic [7:0] mean_large(logic [11:0] s);
      logic [23:0] prod;
      prod = 24'(s) * 24'd2521;
      return prod[22:15];
   endfunction

   function automatic logic [DIST_W-1:0] l1_dist(pixel_type p, pixel_type m);
      return DIST_W'(absdiff(chan(p, 0), chan(m, 0))) +
             DIST_W'(absdiff(chan(p, 1), chan(m, 1))) +
             DIST_W'(absdiff(chan(p, 2), chan(m, 2)));
   endfunction

   // Index of the first least entry; ties keep the lower index.
   function automatic logic [TREE_IDX_W-1:0] argmin_tree(tree_type d);
      tree_type dv;
      logic [TREE_N-1:0][TREE_IDX_W-1:0] iv;
      int step;
      dv = d;
      for (int i = 0; i < TREE_N; i++) iv[i] = TREE_IDX_W'(i);
      for (int l = 0; l < TREE_IDX_W; l++) begin
         step = 1 << l;
         for (int i = 0; i < TREE_N; i = i + 2 * step) begin
            if (dv[i + step] < dv[i]) begin
               dv[i] = dv[i + step];
               iv[i] = iv[i + step];
            end
         end
      end
      return iv[0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/mnpd_req_if.sv
// Input channel of the denoiser: raster pixels and pad ticks.
// No dependencies.
`default_nettype none
interface mnpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_blue;
   logic [7:0] pixel_green;
   logic [7:0] pixel_red;
   logic       is_pad;
   modport source (output valid, pixel_blue, pixel_green, pixel_red, is_pad, input ready);
   modport sink   (input valid, pixel_blue, pixel_green, pixel_red, is_pad, output ready);
endinterface
`default_nettype wire

FILE: rtl/mnpd_rsp_if.sv
// Result channel of the denoiser: filtered or passed-through pixels.
// No dependencies.
`default_nettype none
interface mnpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_blue;
   logic [7:0] out_green;
   logic [7:0] out_red;
   logic       frame_done;
   modport source (output valid, out_blue, out_green, out_red, frame_done, input ready);
   modport sink   (input valid, out_blue, out_green, out_red, frame_done, output ready);
endinterface
`default_nettype wire

FILE: rtl/mean_nearest_pixel_denoise.sv
// Mean-nearest-pixel denoiser for 24-bit BGR raster pixels. One transaction is taken
// per clock: the line-store RAM port, the window shift and every pipeline stage work on
// a new pixel each cycle, so the sustained rate is one pixel per cycle with stalls only
// from the result side. Results pass the issue, window, mean, distance and result
// registers; results lag input by 2*W+2 transactions, so send 2*W+2 pad transactions
// after the last pixel to flush a frame. Interior pixels get the average of the 3x3 and
// 13-pixel nearest-to-mean picks; border pixels pass unchanged. Write frame_width and
// frame_height only while idle; values are clamped to 5..MAX_WIDTH and 5..2048.
// Depends on mnpd_pkg, the channel interfaces, mnpd_front and mnpd_pick.
`default_nettype none
module mean_nearest_pixel_denoise #(
   parameter int MAX_WIDTH = mnpd_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   mnpd_req_if.sink                             req_chan,
   mnpd_rsp_if.source                           rsp_chan,
   input  wire logic                            csr_we,
   input  wire logic [mnpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mnpd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   localparam int WW = $clog2(MAX_WIDTH) + 1;

   logic [mnpd_pkg::CFG_WIDTH_W-1:0]  frame_width_ff;
   logic [mnpd_pkg::CFG_HEIGHT_W-1:0] frame_height_ff;
   logic [WW-1:0]                     width_used;
   logic [mnpd_pkg::IN_ROW_W-1:0]     height_used;
   logic                              b_valid, b_ready;
   mnpd_pkg::window_type              window;
   mnpd_pkg::tag_type                 b_tag;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= mnpd_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= mnpd_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mnpd_pkg::REG_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[mnpd_pkg::CFG_WIDTH_W-1:0];
            mnpd_pkg::REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (32'(frame_width_ff) > 32'(MAX_WIDTH)) width_used = WW'(MAX_WIDTH);
      else if (32'(frame_width_ff) < 32'(mnpd_pkg::MIN_DIM)) width_used = WW'(mnpd_pkg::MIN_DIM);
      else width_used = WW'(frame_width_ff);
      if (frame_height_ff > 12'(mnpd_pkg::MAX_HEIGHT)) height_used = 12'(mnpd_pkg::MAX_HEIGHT);
      else if (frame_height_ff < 12'(mnpd_pkg::MIN_DIM)) height_used = 12'(mnpd_pkg::MIN_DIM);
      else height_used = frame_height_ff;
   end

   mnpd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .width_used  (width_used),
      .height_used (height_used),
      .req         (req_chan),
      .b_valid     (b_valid),
      .b_ready     (b_ready),
      .window      (window),
      .b_tag       (b_tag)
   );

   mnpd_pick u_pick (
      .clock   (clock),
      .reset   (reset),
      .b_valid (b_valid),
      .b_ready (b_ready),
      .window  (window),
      .b_tag   (b_tag),
      .rsp     (rsp_chan)
   );
endmodule
`default_nettype wire

FILE: rtl/mnpd_ram.sv
// Generic single-address RAM with registered, read-first output.
// No dependencies.
`default_nettype none
module mnpd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      if (re) rdata <= mem[addr];
   end
endmodule
`default_nettype wire

FILE: rtl/mnpd_front.sv
// Input side: raster counters, four line-store RAMs, issue stage and the 5x5 window.
// Depends on mnpd_pkg, mnpd_req_if and mnpd_ram.
`default_nettype none
module mnpd_front #(
   parameter int MAX_WIDTH = mnpd_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [$clog2(MAX_WIDTH):0]    width_used,
   input  wire logic [mnpd_pkg::IN_ROW_W-1:0] height_used,
   mnpd_req_if.sink                           req,
   output logic                               b_valid,
   input  wire logic                          b_ready,
   output mnpd_pkg::window_type               window,
   output mnpd_pkg::tag_type                  b_tag
);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = AW + 1;
   localparam int NW = WW + mnpd_pkg::IN_ROW_W;
   localparam int RW = mnpd_pkg::IN_ROW_W;
   localparam int OW = mnpd_pkg::OUT_ROW_W;

   logic [AW-1:0] in_column_ff, in_column_in, out_column_ff, out_column_in;
   logic [RW-1:0] in_row_ff, in_row_in;
   logic [OW-1:0] out_row_ff, out_row_in;

   logic                 va_ff, a_pad_ff, a_prod_ff, vb_ff;
   mnpd_pkg::pixel_type  a_pix_ff;
   logic [1:0]           a_slot_ff;
   mnpd_pkg::tag_type    a_tag_ff, b_tag_ff, tag_now;
   mnpd_pkg::window_type window_ff, window_in;

   logic                 pad, start_new, ignore, acc, live, prod, done, interior;
   logic                 ready_a, take_b, a_move;
   mnpd_pkg::pixel_type  pix;
   logic [AW-1:0]        col, ocol;
   logic [RW-1:0]        row;
   logic [OW-1:0]        orow;
   logic [NW-1:0]        n_pos, n_lim;
   logic [WW-1:0]        col_inc, ocol_inc;
   mnpd_pkg::pixel_type  rd [mnpd_pkg::STORED_ROWS];
   mnpd_pkg::pixel_type  newcol [5];

   assign pad       = req.is_pad;
   assign pix       = {req.pixel_red, req.pixel_green, req.pixel_blue};
   assign start_new = !pad && (in_row_ff >= height_used);
   assign ignore    = pad && (in_row_ff < height_used);
   assign take_b    = !vb_ff || b_ready;
   assign ready_a   = !va_ff || take_b;
   assign req.ready = ready_a;
   assign acc       = req.valid && ready_a;
   assign live      = acc && !ignore;
   assign a_move    = va_ff && take_b;

   always_comb begin
      row  = start_new ? '0 : in_row_ff;
      col  = start_new ? '0 : in_column_ff;
      orow = start_new ? '0 : out_row_ff;
      ocol = start_new ? '0 : out_column_ff;

      n_pos = NW'(row) * NW'(width_used) + NW'(col);
      n_lim = (NW'(width_used) << 1) + NW'(2);
      prod  = n_pos >= n_lim;

      interior = (orow >= OW'(2)) && ((13'(orow) + 13'd3) <= 13'(height_used)) &&
                 (ocol >= AW'(2)) && (({1'b0, ocol} + WW'(3)) <= width_used);
      done = ({1'b0, orow} >= (height_used - 12'd1)) &&
             ({1'b0, ocol} >= (width_used - WW'(1)));
      tag_now.filt = interior;
      tag_now.done = done;

      col_inc  = {1'b0, col} + WW'(1);
      ocol_inc = {1'b0, ocol} + WW'(1);

      in_column_in  = in_column_ff;
      in_row_in     = in_row_ff;
      out_column_in = out_column_ff;
      out_row_in    = out_row_ff;
      if (live) begin
         if (col_inc >= width_used) begin
            in_column_in = '0;
            in_row_in    = row + RW'(1);
         end else begin
            in_column_in = col_inc[AW-1:0];
            in_row_in    = row;
         end
         out_column_in = ocol;
         out_row_in    = orow;
         if (prod) begin
            if (ocol_inc >= width_used) begin
               out_column_in = '0;
               out_row_in    = orow + OW'(1);
            end else begin
               out_column_in = ocol_inc[AW-1:0];
            end
            if (done) begin
               in_column_in  = '0;
               in_row_in     = '0;
               out_column_in = '0;
               out_row_in    = '0;
            end
         end
      end
   end

   for (genvar s = 0; s < mnpd_pkg::STORED_ROWS; s++) begin : g_line
      mnpd_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_line (
         .clock (clock),
         .we    (live && !pad && (row[1:0] == 2'(s))),
         .re    (acc),
         .addr  (col),
         .wdata (pix),
         .rdata (rd[s])
      );
   end

   // Oldest row lands in window row 0, the live pixel in row 4.
   always_comb begin
      for (int k = 0; k < 4; k++) newcol[k] = rd[2'(a_slot_ff + 2'(k))];
      newcol[4] = a_pad_ff ? '0 : a_pix_ff;
      window_in = window_ff;
      for (int r = 0; r < 5; r++) begin
         for (int k = 0; k < 4; k++) window_in[r*5 + k] = window_ff[r*5 + k + 1];
         window_in[r*5 + 4] = newcol[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff  <= '0;
         in_row_ff     <= '0;
         out_column_ff <= '0;
         out_row_ff    <= '0;
         va_ff         <= 1'b0;
         vb_ff         <= 1'b0;
         window_ff     <= '0;
      end else begin
         in_column_ff  <= in_column_in;
         in_row_ff     <= in_row_in;
         out_column_ff <= out_column_in;
         out_row_ff    <= out_row_in;
         if (ready_a) va_ff <= live;
         if (take_b) vb_ff <= a_move && a_prod_ff;
         if (a_move) window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (live) begin
         a_pad_ff  <= pad;
         a_pix_ff  <= pix;
         a_slot_ff <= row[1:0];
         a_prod_ff <= prod;
         a_tag_ff  <= tag_now;
      end
      if (a_move) b_tag_ff <= a_tag_ff;
   end

   assign b_valid = vb_ff;
   assign window  = window_ff;
   assign b_tag   = b_tag_ff;

`ifndef SYNTHESIS
   a_done_restart: assert property (@(posedge clock) disable iff (reset)
      (live && prod && done) |=> (in_row_ff == '0 && in_column_ff == '0 && out_row_ff == '0))
      else $error("frame end did not restart the counters");
   a_pad_ignored: assert property (@(posedge clock) disable iff (reset)
      (acc && ignore) |=> ($stable(in_row_ff) && $stable(in_column_ff)))
      else $error("ignored pad moved the input position");
   a_window_hold: assert property (@(posedge clock) disable iff (reset)
      (vb_ff && !b_ready) |=> $stable(window_ff))
      else $error("window changed under a stalled stage");
`endif
endmodule
`default_nettype wire

FILE: rtl/mnpd_pick.sv
// Output side: set means, L1 distances, nearest pick and average, result register.
// Depends on mnpd_pkg and mnpd_rsp_if.
`default_nettype none
module mnpd_pick (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 b_valid,
   output logic                      b_ready,
   input  wire mnpd_pkg::window_type window,
   input  wire mnpd_pkg::tag_type    b_tag,
   mnpd_rsp_if.source                rsp
);
   localparam int NS = mnpd_pkg::SET_SMALL;
   localparam int NL = mnpd_pkg::SET_LARGE;
   localparam int DW = mnpd_pkg::DIST_W;

   logic vc_ff, vd_ff, ve_ff, take_c, take_d, take_e;
   mnpd_pkg::set_type   set_b, c_set_ff, d_set_ff;
   mnpd_pkg::pixel_type m_small, m_large, c_ms_ff, c_ml_ff, e_pix_ff, res;
   mnpd_pkg::tag_type   c_tag_ff, d_tag_ff;
   logic [NS-1:0][DW-1:0] d_ds_in, d_ds_ff;
   logic [NL-1:0][DW-1:0] d_dl_in, d_dl_ff;
   logic                  e_done_ff;
   mnpd_pkg::tree_type    tree_s, tree_l;
   logic [mnpd_pkg::TREE_IDX_W-1:0] ia, ib;
   logic [11:0] sum_s, sum_l;

   assign take_e  = !ve_ff || rsp.ready;
   assign take_d  = !vd_ff || take_e;
   assign take_c  = !vc_ff || take_d;
   assign b_ready = take_c;

   // 3x3 first, then up, down, left, right at distance two.
   always_comb begin
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++) set_b[r*3 + c] = window[(r+1)*5 + c + 1];
      set_b[9]  = window[2];
      set_b[10] = window[22];
      set_b[11] = window[10];
      set_b[12] = window[14];
      for (int ch = 0; ch < 3; ch++) begin
         sum_s = '0;
         for (int k = 0; k < NS; k++) sum_s = sum_s + 12'(mnpd_pkg::chan(set_b[k], ch));
         sum_l = sum_s;
         for (int k = NS; k < NL; k++) sum_l = sum_l + 12'(mnpd_pkg::chan(set_b[k], ch));
         m_small[8*ch +: 8] = mnpd_pkg::mean_small(sum_s);
         m_large[8*ch +: 8] = mnpd_pkg::mean_large(sum_l);
      end
   end

   always_comb begin
      for (int k = 0; k < NS; k++) d_ds_in[k] = mnpd_pkg::l1_dist(c_set_ff[k], c_ms_ff);
      for (int k = 0; k < NL; k++) d_dl_in[k] = mnpd_pkg::l1_dist(c_set_ff[k], c_ml_ff);
   end

   always_comb begin
      for (int k = 0; k < mnpd_pkg::TREE_N; k++) begin
         tree_s[k] = (k < NS) ? {1'b0, d_ds_ff[k % NS]} : '1;
         tree_l[k] = (k < NL) ? {1'b0, d_dl_ff[k % NL]} : '1;
      end
      ia = mnpd_pkg::argmin_tree(tree_s);
      ib = mnpd_pkg::argmin_tree(tree_l);
      for (int ch = 0; ch < 3; ch++)
         res[8*ch +: 8] = 8'((9'(mnpd_pkg::chan(d_set_ff[ia], ch)) +
                              9'(mnpd_pkg::chan(d_set_ff[ib], ch))) >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else begin
         if (take_c) vc_ff <= b_valid;
         if (take_d) vd_ff <= vc_ff;
         if (take_e) ve_ff <= vd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take_c && b_valid) begin
         c_set_ff <= set_b;
         c_ms_ff  <= m_small;
         c_ml_ff  <= m_large;
         c_tag_ff <= b_tag;
      end
      if (take_d && vc_ff) begin
         d_set_ff <= c_set_ff;
         d_ds_ff  <= d_ds_in;
         d_dl_ff  <= d_dl_in;
         d_tag_ff <= c_tag_ff;
      end
      // Border pixels pass the window center through.
      if (take_e && vd_ff) begin
         e_pix_ff  <= d_tag_ff.filt ? res : d_set_ff[4];
         e_done_ff <= d_tag_ff.done;
      end
   end

   assign rsp.valid      = ve_ff;
   assign rsp.out_blue   = e_pix_ff[7:0];
   assign rsp.out_green  = e_pix_ff[15:8];
   assign rsp.out_red    = e_pix_ff[23:16];
   assign rsp.frame_done = e_done_ff;

`ifndef SYNTHESIS
   a_d_hold: assert property (@(posedge clock) disable iff (reset)
      (vd_ff && !take_e) |=> (vd_ff && $stable(d_tag_ff)))
      else $error("distance stage lost a stalled transaction");
   a_c_hold: assert property (@(posedge clock) disable iff (reset)
      (vc_ff && !take_d) |=> vc_ff)
      else $error("mean stage lost a stalled transaction");
   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(ve_ff) |-> $past(vd_ff))
      else $error("result appeared without a transaction behind it");
`endif
endmodule
`default_nettype wire
